// ===== rtl/lpht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

    // Default sizes of the table.
    localparam int INDEX_BITS_DEF   = 6;
    localparam int HANDLER_BITS_DEF = 32;

    // Fixed widths of the transaction fields.
    localparam int KEY_BITS         = 9;
    localparam int IN_HANDLER_BITS  = 32;
    localparam int OUT_HANDLER_BITS = 32;
    localparam int STATUS_BITS      = 2;

    // Operation codes of the cmd field.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Result codes of the status field.
    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_INSERTED = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_FOUND    = 2'd2,
        STATUS_MISSING  = 2'd3
    } status_code_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic         clear_we;
        logic         accept;
        logic         advance;
        logic         write_slot;
        logic         finish;
        status_code_t code;
        logic         load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic slot_used;
        logic key_match;
        logic wrap_last;
        logic is_lookup;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/lpht_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpht_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_stall,
    input  wire lpht_pkg::dp_status_t   dp_status,
    output lpht_pkg::ctrl_cmd_t         ctl_cmd
);
    import lpht_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // New transactions are taken only while no operation is in flight.
    assign req_stall = (state_reg != ST_IDLE);

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        ctl_cmd    = '0;
        ctl_cmd.code = STATUS_INSERTED;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl_cmd.clear_we = 1'b1;
                if (dp_status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    ctl_cmd.accept = 1'b1;
                    state_next     = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (!dp_status.is_lookup)
                begin
                    // Insert fills the first empty slot on the probe path.
                    if (!dp_status.slot_used)
                    begin
                        ctl_cmd.write_slot = 1'b1;
                        ctl_cmd.finish     = 1'b1;
                        ctl_cmd.code       = STATUS_INSERTED;
                    end
                    else if (dp_status.wrap_last)
                    begin
                        ctl_cmd.finish = 1'b1;
                        ctl_cmd.code   = STATUS_FULL;
                    end
                    else
                    begin
                        ctl_cmd.advance = 1'b1;
                    end
                end
                else
                begin
                    // Lookup stops at an empty slot or at the first matching key.
                    if (!dp_status.slot_used)
                    begin
                        ctl_cmd.finish = 1'b1;
                        ctl_cmd.code   = STATUS_MISSING;
                    end
                    else if (dp_status.key_match)
                    begin
                        ctl_cmd.finish = 1'b1;
                        ctl_cmd.code   = STATUS_FOUND;
                    end
                    else if (dp_status.wrap_last)
                    begin
                        ctl_cmd.finish = 1'b1;
                        ctl_cmd.code   = STATUS_MISSING;
                    end
                    else
                    begin
                        ctl_cmd.advance = 1'b1;
                    end
                end
                if (ctl_cmd.finish)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (dp_status.out_free)
                begin
                    ctl_cmd.load_out = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State register; reset starts the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A probe step either moves on or ends the operation, never both.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl_cmd.advance && ctl_cmd.finish))
        else $error("probe advanced and finished in the same cycle");

    // An accepted transaction always starts probing in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.accept |=> (state_reg == ST_PROBE))
        else $error("accepted transaction did not start probing");

    // A slot is written only when an insert completes successfully.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.write_slot |-> (ctl_cmd.finish && ctl_cmd.code == STATUS_INSERTED))
        else $error("slot written without a completed insert");

endmodule

`default_nettype wire

// ===== rtl/lpht_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpht_datapath #(
    parameter int INDEX_BITS   = lpht_pkg::INDEX_BITS_DEF,
    parameter int HANDLER_BITS = lpht_pkg::HANDLER_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cmd,
    input  wire logic [lpht_pkg::KEY_BITS-1:0]         key,
    input  wire logic [lpht_pkg::IN_HANDLER_BITS-1:0]  handler,
    input  wire logic                                  rsp_stall,
    output logic                                       rsp_valid,
    output logic [lpht_pkg::STATUS_BITS-1:0]           status,
    output logic [lpht_pkg::OUT_HANDLER_BITS-1:0]      found_handler,
    input  wire lpht_pkg::ctrl_cmd_t                   ctl_cmd,
    output lpht_pkg::dp_status_t                       dp_status
);
    import lpht_pkg::*;

    localparam int SLOTS    = 1 << INDEX_BITS;
    localparam int KEY_WIDE = (INDEX_BITS > KEY_BITS) ? INDEX_BITS : KEY_BITS;
    localparam int HIN_WIDE = (HANDLER_BITS > IN_HANDLER_BITS) ? HANDLER_BITS
                                                                : IN_HANDLER_BITS;
    localparam int HOUT_WIDE = (HANDLER_BITS > OUT_HANDLER_BITS) ? HANDLER_BITS
                                                                  : OUT_HANDLER_BITS;

    typedef struct packed {
        logic                    used;
        logic [KEY_BITS-1:0]     key;
        logic [HANDLER_BITS-1:0] handler;
    } slot_t;

    // Slot memory with one write port and one registered read port.
    slot_t mem [SLOTS];
    slot_t rd_data_reg;

    logic                        wr_en;
    logic [INDEX_BITS-1:0]       wr_addr;
    slot_t                       wr_data;
    logic                        rd_en;
    logic [INDEX_BITS-1:0]       rd_addr;

    logic [INDEX_BITS-1:0]       clear_addr_reg;
    logic                        item_cmd_reg;
    logic [KEY_BITS-1:0]         item_key_reg;
    logic [HANDLER_BITS-1:0]     item_handler_reg;
    logic [INDEX_BITS-1:0]       home_reg;
    logic [INDEX_BITS-1:0]       cur_addr_reg;
    logic [INDEX_BITS-1:0]       next_addr;
    logic [INDEX_BITS-1:0]       home;

    status_code_t                res_code_reg;
    logic [OUT_HANDLER_BITS-1:0] res_handler_reg;
    status_code_t                status_reg;
    logic [OUT_HANDLER_BITS-1:0] found_handler_reg;
    logic                        rsp_valid_reg;

    logic [KEY_WIDE-1:0]         key_wide;
    logic [HIN_WIDE-1:0]         hin_wide;
    logic [HOUT_WIDE-1:0]        hout_wide;
    logic [HANDLER_BITS-1:0]     stored_handler;
    logic [OUT_HANDLER_BITS-1:0] slot_handler_out;

    // Home slot and handler width adaptation.
    always_comb
    begin
        key_wide = '0;
        key_wide[KEY_BITS-1:0] = key;
        home = key_wide[INDEX_BITS-1:0];

        hin_wide = '0;
        hin_wide[IN_HANDLER_BITS-1:0] = handler;
        stored_handler = hin_wide[HANDLER_BITS-1:0];

        hout_wide = '0;
        hout_wide[HANDLER_BITS-1:0] = rd_data_reg.handler;
        slot_handler_out = hout_wide[OUT_HANDLER_BITS-1:0];
    end

    assign next_addr = cur_addr_reg + INDEX_BITS'(1);

    // Write port: clearing pass after reset, or the slot found by an insert.
    always_comb
    begin
        wr_en   = ctl_cmd.clear_we || ctl_cmd.write_slot;
        wr_addr = ctl_cmd.clear_we ? clear_addr_reg : cur_addr_reg;
        if (ctl_cmd.clear_we)
        begin
            wr_data = '0;
        end
        else
        begin
            wr_data.used    = 1'b1;
            wr_data.key     = item_key_reg;
            wr_data.handler = item_handler_reg;
        end
    end

    // Read port: the home slot on accept, the following slot on each step.
    assign rd_en   = ctl_cmd.accept || ctl_cmd.advance;
    assign rd_addr = ctl_cmd.accept ? home : next_addr;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control registers: clear pointer and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl_cmd.clear_we)
            begin
                clear_addr_reg <= clear_addr_reg + INDEX_BITS'(1);
            end
            if (ctl_cmd.load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: current transaction, probe pointer and results.
    always_ff @(posedge clk)
    begin
        if (ctl_cmd.accept)
        begin
            item_cmd_reg     <= cmd;
            item_key_reg     <= key;
            item_handler_reg <= stored_handler;
            home_reg         <= home;
            cur_addr_reg     <= home;
        end
        else if (ctl_cmd.advance)
        begin
            cur_addr_reg <= next_addr;
        end
        if (ctl_cmd.finish)
        begin
            res_code_reg    <= ctl_cmd.code;
            res_handler_reg <= (ctl_cmd.code == STATUS_FOUND) ? slot_handler_out : '0;
        end
        if (ctl_cmd.load_out)
        begin
            status_reg        <= res_code_reg;
            found_handler_reg <= res_handler_reg;
        end
    end

    // Status toward the controller.
    always_comb
    begin
        dp_status.clear_last = (clear_addr_reg == {INDEX_BITS{1'b1}});
        dp_status.slot_used  = rd_data_reg.used;
        dp_status.key_match  = (rd_data_reg.key == item_key_reg);
        dp_status.wrap_last  = (next_addr == home_reg);
        dp_status.is_lookup  = (item_cmd_reg == CMD_LOOKUP);
        dp_status.out_free   = !rsp_valid_reg || !rsp_stall;
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign found_handler = found_handler_reg;

    // An insert writes only into a slot that was read as empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.write_slot |-> (!rd_data_reg.used && item_cmd_reg == CMD_INSERT))
        else $error("insert wrote into an occupied slot");

    // The output register is loaded only when its previous result is gone.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.load_out |-> (!rsp_valid_reg || !rsp_stall))
        else $error("result overwrote a pending result");

    // A loaded result shows up with the code the probe ended with.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.load_out |=> (rsp_valid_reg && status_reg == $past(res_code_reg)))
        else $error("loaded result not presented");

endmodule

`default_nettype wire

// ===== rtl/linear_probe_hash_table_core.sv =====
//  Channel   Direction   Handshake               Fields
//  request   in          req_valid / req_stall   cmd, key, handler
//  response  out         rsp_valid / rsp_stall   status, found_handler
//
//  An operation probes 1 to 2^INDEX_BITS slots between acceptance and a loaded
//  result, one slot per cycle through the single registered read port of the slot
//  memory; the next request is taken in the cycle after the result is loaded.
//  After reset a clearing pass empties every slot; requests stall until it ends.
//  A new request is taken while a result waits in the output register; rsp_stall
//  holds that result and delays the next one.
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table_core #(
    parameter int INDEX_BITS   = lpht_pkg::INDEX_BITS_DEF,
    parameter int HANDLER_BITS = lpht_pkg::HANDLER_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  req_valid,
    output logic                                       req_stall,
    input  wire logic                                  cmd,
    input  wire logic [lpht_pkg::KEY_BITS-1:0]         key,
    input  wire logic [lpht_pkg::IN_HANDLER_BITS-1:0]  handler,
    output logic                                       rsp_valid,
    input  wire logic                                  rsp_stall,
    output logic [lpht_pkg::STATUS_BITS-1:0]           status,
    output logic [lpht_pkg::OUT_HANDLER_BITS-1:0]      found_handler
);
    import lpht_pkg::*;

    ctrl_cmd_t  ctl_cmd;
    dp_status_t dp_status;

    // Sequencer for clearing, probing and result hand-off.
    lpht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .dp_status (dp_status),
        .ctl_cmd   (ctl_cmd)
    );

    // Slot memory, probe pointer and output register.
    lpht_datapath #(
        .INDEX_BITS   (INDEX_BITS),
        .HANDLER_BITS (HANDLER_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .key           (key),
        .handler       (handler),
        .rsp_stall     (rsp_stall),
        .rsp_valid     (rsp_valid),
        .status        (status),
        .found_handler (found_handler),
        .ctl_cmd       (ctl_cmd),
        .dp_status     (dp_status)
    );

endmodule

`default_nettype wire

// ===== bench/tb_linear_probe_hash_table_core.sv =====
`timescale 1ns / 1ps

module tb_linear_probe_hash_table_core;

    import lpht_pkg::*;

    localparam int INDEX_BITS = INDEX_BITS_DEF;
    localparam int SLOT_COUNT = 1 << INDEX_BITS;
    localparam int RANDOM_ITEMS = 1080;
    localparam int PHASE_ITEMS = RANDOM_ITEMS / 3;
    localparam logic [IN_HANDLER_BITS-1:0] ALL_ONES = '1;

    // One expected response transaction.
    typedef struct {
        status_code_t                status;
        logic [OUT_HANDLER_BITS-1:0] found_handler;
    } table_result_t;

    // Shadow copy of the slot table; predicts each response from the request stream.
    class hash_table_scoreboard;
        bit                         slot_taken[SLOT_COUNT];
        logic [KEY_BITS-1:0]        slot_key[SLOT_COUNT];
        logic [IN_HANDLER_BITS-1:0] slot_value[SLOT_COUNT];
        table_result_t              awaited[$];
        int                         failures;

        function new();
            foreach (slot_taken[i])
            begin
                slot_taken[i] = 1'b0;
            end
            failures = 0;
        endfunction

        // Probe from the home slot, wrapping, exactly as the table does.
        function void note_request(logic op, logic [KEY_BITS-1:0] k,
                                   logic [IN_HANDLER_BITS-1:0] h);
            table_result_t r;
            int home;
            int s;
            home = int'(k[INDEX_BITS-1:0]);
            r.found_handler = '0;
            if (op == CMD_INSERT)
            begin
                r.status = STATUS_FULL;
            end
            else
            begin
                r.status = STATUS_MISSING;
            end
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                s = (home + i) % SLOT_COUNT;
                if (op == CMD_INSERT)
                begin
                    if (!slot_taken[s])
                    begin
                        slot_taken[s] = 1'b1;
                        slot_key[s]   = k;
                        slot_value[s] = h;
                        r.status      = STATUS_INSERTED;
                        break;
                    end
                end
                else
                begin
                    if (!slot_taken[s])
                    begin
                        break;
                    end
                    if (slot_key[s] == k)
                    begin
                        r.status        = STATUS_FOUND;
                        r.found_handler = slot_value[s];
                        break;
                    end
                end
            end
            awaited.push_back(r);
        endfunction

        // Compare one response with the oldest prediction.
        function void check_response(logic [STATUS_BITS-1:0] st,
                                     logic [OUT_HANDLER_BITS-1:0] fh);
            table_result_t r;
            if (awaited.size() == 0)
            begin
                $error("unexpected response: status %0d found_handler %h", st, fh);
                failures++;
                return;
            end
            r = awaited.pop_front();
            if (st !== r.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", r.status, st);
                failures++;
            end
            if (fh !== r.found_handler)
            begin
                $error("found_handler mismatch: expected %h, actual %h",
                       r.found_handler, fh);
                failures++;
            end
        endfunction

        // Any prediction still waiting at the end is a lost response.
        function void check_drained();
            foreach (awaited[i])
            begin
                $error("missing response: status %0d found_handler %h",
                       awaited[i].status, awaited[i].found_handler);
                failures++;
            end
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        req_valid = 1'b0;
    logic                        req_stall;
    logic                        cmd = CMD_INSERT;
    logic [KEY_BITS-1:0]         key = '0;
    logic [IN_HANDLER_BITS-1:0]  handler = '0;
    logic                        rsp_valid;
    logic                        rsp_stall = 1'b0;
    logic [STATUS_BITS-1:0]      status;
    logic [OUT_HANDLER_BITS-1:0] found_handler;

    int sender_idle_pct = 9;
    int receiver_stall_pct = 58;

    hash_table_scoreboard   table_model;
    logic [KEY_BITS-1:0]    stored_keys[$];

    linear_probe_hash_table_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .cmd           (cmd),
        .key           (key),
        .handler       (handler),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .found_handler (found_handler)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver back-pressure changes on the falling edge.
    always @(negedge clk)
    begin
        rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    // Every accepted response transaction is checked at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            table_model.check_response(status, found_handler);
        end
    end

    // Drive one request transaction, with an occasional idle gap ahead of it.
    task automatic send_request(input logic op, input logic [KEY_BITS-1:0] k,
                                input logic [IN_HANDLER_BITS-1:0] h);
        int gap;
        gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, 6) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        cmd       <= op;
        key       <= k;
        handler   <= h;
        do
            @(posedge clk);
        while (req_stall);
        table_model.note_request(op, k, h);
        if (op == CMD_INSERT)
        begin
            stored_keys.push_back(k);
        end
    endtask

    // Mostly lookups, with enough inserts to fill the table part way through.
    task automatic send_random_item();
        logic                       op;
        logic [KEY_BITS-1:0]        k;
        logic [IN_HANDLER_BITS-1:0] h;
        int                         pick;
        op = ($urandom_range(0, 99) < 12) ? CMD_INSERT : CMD_LOOKUP;
        k = KEY_BITS'($urandom_range(0, (1 << KEY_BITS) - 1));
        pick = $urandom_range(0, 99);
        if (stored_keys.size() > 0)
        begin
            // Reuse a stored key, or aim a different key at the same home slot.
            if (pick < ((op == CMD_LOOKUP) ? 50 : 25))
            begin
                k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            end
            else if (pick < 70)
            begin
                k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                k[KEY_BITS-1:INDEX_BITS] = (KEY_BITS - INDEX_BITS)'(
                    $urandom_range(0, (1 << (KEY_BITS - INDEX_BITS)) - 1));
            end
        end
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            h = '0;
        end
        else if (pick == 1)
        begin
            h = ALL_ONES;
        end
        else
        begin
            h = $urandom();
        end
        send_request(op, k, h);
    endtask

    // Main sequence.
    initial
    begin
        int drain;
        table_model = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed cases on an empty table: zero handler, duplicates, wrap-around.
        send_request(CMD_LOOKUP, 9'd0,   32'h0);
        send_request(CMD_INSERT, 9'd0,   32'h0);
        send_request(CMD_LOOKUP, 9'd0,   32'h0);
        send_request(CMD_LOOKUP, 9'd64,  ALL_ONES);
        send_request(CMD_INSERT, 9'd64,  ALL_ONES);
        send_request(CMD_INSERT, 9'd0,   32'h1234_5678);
        send_request(CMD_LOOKUP, 9'd0,   32'h0);
        send_request(CMD_LOOKUP, 9'd64,  32'h0);
        send_request(CMD_INSERT, 9'd511, 32'hA5A5_A5A5);
        send_request(CMD_INSERT, 9'd127, 32'h5A5A_5A5A);
        send_request(CMD_LOOKUP, 9'd127, 32'h0);
        send_request(CMD_LOOKUP, 9'd1,   32'h0);
        send_request(CMD_LOOKUP, 9'd511, 32'h0);
        send_request(CMD_LOOKUP, 9'd448, 32'h0);

        // Random traffic in three back-pressure phases.
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            send_random_item();
        end
        sender_idle_pct    = 58;
        receiver_stall_pct = 9;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            send_random_item();
        end
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            send_random_item();
        end
        @(negedge clk);
        req_valid <= 1'b0;

        // Let outstanding responses arrive, then allow one full probe of slack.
        drain = 0;
        while (table_model.awaited.size() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SLOT_COUNT + 16) @(posedge clk);
        table_model.check_drained();
        if (table_model.failures == 0)
        begin
            $display("PASS linear_probe_hash_table_core");
        end
        else
        begin
            $display("FAIL linear_probe_hash_table_core");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2_000_000;
        $display("FAIL linear_probe_hash_table_core");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lpht_pkg.sv
rtl/lpht_ctrl.sv
rtl/lpht_datapath.sv
rtl/linear_probe_hash_table_core.sv
bench/tb_linear_probe_hash_table_core.sv
